[sv/pidc_pkg.sv]
package pidc_pkg;

    localparam int DATA_W = 32;
    localparam int DT_W = 16;
    localparam int LIM_W = 31;
    localparam int CFG_ADDR_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INT_LIM = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_LIM = 3'd4;

    // 1000.0 in Q16.16, used for a limit written as zero.
    localparam logic [LIM_W-1:0] LIMIT_DEFAULT = 31'd65536000;

    // Input command codes.
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Operand selection of the shared multiplier.
    localparam logic [1:0] MUL_INC = 2'd0;
    localparam logic [1:0] MUL_P = 2'd1;
    localparam logic [1:0] MUL_I = 2'd2;
    localparam logic [1:0] MUL_D = 2'd3;

    typedef struct packed {
        logic       load;
        logic       clear_state;
        logic       div_start;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       int_upd;
        logic       acc_add;
        logic       commit_last;
        logic       res_zero;
    } pidc_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic dt_zero;
        logic div_done;
    } pidc_status_t;

endpackage

[sv/pidc_div.sv]
module pidc_div
    import pidc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W:0]   diff,
    input  logic [DT_W-1:0]          divisor,
    output logic                     done,
    output logic signed [DATA_W-1:0] quot
);

    // The dividend is |diff| * 2^16, one quotient bit per cycle.
    localparam int NUM_W = DATA_W + 1 + DT_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DT_W-1:0]  rem_reg, rem_next;
    logic [DT_W-1:0]  dvs_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DATA_W:0]  mag;
    logic [DT_W:0]    trial;
    logic [DT_W:0]    trial_sub;
    logic             ge;

    assign mag = diff[DATA_W] ? (DATA_W+1)'(0) - diff : diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, dvs_reg};
        ge = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], ge};
        cnt_next = cnt_reg - CNT_W'(1);
        busy_next = busy_reg && (cnt_reg != CNT_W'(1));
        done_next = done_reg || (busy_reg && (cnt_reg == CNT_W'(1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= {mag, {DT_W{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= diff[DATA_W];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Truncation toward zero, then saturation to signed 32 bits.
    always_comb
    begin
        if (!neg_reg)
        begin
            if (quo_reg > NUM_W'(32'h7FFF_FFFF))
                quot = 32'sh7FFF_FFFF;
            else
                quot = quo_reg[DATA_W-1:0];
        end
        else
        begin
            if (quo_reg > NUM_W'(33'h0_8000_0000))
                quot = 32'sh8000_0000;
            else
                quot = DATA_W'(0) - quo_reg[DATA_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

[sv/pidc_datapath.sv]
module pidc_datapath
    import pidc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [DATA_W-1:0]        cfg_wdata,
    input  logic                     in_cmd,
    input  logic signed [DATA_W-1:0] in_error,
    input  logic [DT_W-1:0]          in_dt,
    input  pidc_cmd_t                cmd,
    output pidc_status_t             status,
    output logic signed [DATA_W-1:0] result
);

    localparam int PROD_W = 2 * DATA_W + 1;
    localparam int TERM_W = PROD_W - 16;
    localparam int ISUM_W = DATA_W + 2;
    localparam int ACC_W = TERM_W + 2;

    logic signed [DATA_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIM_W-1:0]         ilim_reg, olim_reg;
    logic [LIM_W-1:0]         wr_limit;

    logic                     cmd_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic [DT_W-1:0]          dt_reg;
    logic signed [DATA_W-1:0] integral_reg, integral_next;
    logic signed [DATA_W-1:0] last_err_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W:0]   mul_b;
    logic signed [PROD_W-1:0] rnd_full;
    logic signed [TERM_W-1:0] term;
    logic signed [ISUM_W-1:0] isum, ilim_s;
    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W-1:0] deriv;
    logic signed [DATA_W-1:0] sat, olim_s, clamped;
    logic                     div_done;

    assign wr_limit = (cfg_wdata[LIM_W-1:0] == '0) ? LIMIT_DEFAULT : cfg_wdata[LIM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            ilim_reg <= LIMIT_DEFAULT;
            olim_reg <= LIMIT_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GAIN_P:  gain_p_reg <= cfg_wdata;
                REG_GAIN_I:  gain_i_reg <= cfg_wdata;
                REG_GAIN_D:  gain_d_reg <= cfg_wdata;
                REG_INT_LIM: ilim_reg <= wr_limit;
                REG_OUT_LIM: olim_reg <= wr_limit;
                default:     ;
            endcase
        end
    end

    // Operands of the one shared multiplier.
    always_comb
    begin
        mul_a = err_reg;
        mul_b = $signed({{(DATA_W+1-DT_W){1'b0}}, dt_reg});
        case (cmd.mul_sel)
            MUL_INC:
            begin
                mul_a = err_reg;
                mul_b = $signed({{(DATA_W+1-DT_W){1'b0}}, dt_reg});
            end
            MUL_P:
            begin
                mul_a = gain_p_reg;
                mul_b = {err_reg[DATA_W-1], err_reg};
            end
            MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = {integral_reg[DATA_W-1], integral_reg};
            end
            default:
            begin
                mul_a = gain_d_reg;
                mul_b = {deriv[DATA_W-1], deriv};
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Round half up to Q16.16: add half an LSB and shift with floor.
    assign rnd_full = (prod_reg + PROD_W'(32768)) >>> 16;
    assign term = rnd_full[TERM_W-1:0];

    always_comb
    begin
        isum = {{2{integral_reg[DATA_W-1]}}, integral_reg} + term[ISUM_W-1:0];
        ilim_s = $signed({3'b000, ilim_reg});
        if (isum > ilim_s)
            integral_next = ilim_s[DATA_W-1:0];
        else if (isum < -ilim_s)
            integral_next = DATA_W'(-ilim_s);
        else
            integral_next = isum[DATA_W-1:0];
        acc_next = acc_reg + {{2{term[TERM_W-1]}}, term};
    end

    assign diff = {err_reg[DATA_W-1], err_reg} - {last_err_reg[DATA_W-1], last_err_reg};

    pidc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .diff    (diff),
        .divisor (dt_reg),
        .done    (div_done),
        .quot    (deriv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            last_err_reg <= '0;
        end
        else if (cmd.clear_state)
        begin
            integral_reg <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            if (cmd.int_upd)
                integral_reg <= integral_next;
            if (cmd.commit_last)
                last_err_reg <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg <= in_cmd;
            err_reg <= in_error;
            dt_reg <= in_dt;
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
            acc_reg <= acc_next;
        if (cmd.mul_en)
            prod_reg <= prod_next;
    end

    // Saturate the sum to 32 bits, then apply the output clamp.
    always_comb
    begin
        if (acc_reg > ACC_W'(32'sh7FFF_FFFF))
            sat = 32'sh7FFF_FFFF;
        else if (acc_reg < -ACC_W'(64'sh8000_0000))
            sat = 32'sh8000_0000;
        else
            sat = acc_reg[DATA_W-1:0];
        olim_s = $signed({1'b0, olim_reg});
        if (sat > olim_s)
            clamped = olim_s;
        else if (sat < -olim_s)
            clamped = -olim_s;
        else
            clamped = sat;
    end

    assign result = cmd.res_zero ? '0 : clamped;

    assign status.is_clear = (cmd_reg == CMD_CLEAR);
    assign status.dt_zero = (dt_reg == '0);
    assign status.div_done = div_done;

endmodule

[sv/pidc_ctrl.sv]
module pidc_ctrl
    import pidc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         out_free,
    output logic         out_load,
    input  pidc_status_t status,
    output pidc_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_UPD_INT = 3'd2;
    localparam logic [2:0] ST_ACC_P = 3'd3;
    localparam logic [2:0] ST_ACC_I = 3'd4;
    localparam logic [2:0] ST_WAIT_DIV = 3'd5;
    localparam logic [2:0] ST_ACC_D = 3'd6;
    localparam logic [2:0] ST_OUT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       zero_reg, zero_next;

    always_comb
    begin
        state_next = state_reg;
        zero_next = zero_reg;
        cmd = '0;
        cmd.res_zero = zero_reg;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.is_clear || status.dt_zero)
                begin
                    cmd.clear_state = status.is_clear;
                    zero_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.mul_en = 1'b1;
                    cmd.mul_sel = MUL_INC;
                    zero_next = 1'b0;
                    state_next = ST_UPD_INT;
                end
            end
            ST_UPD_INT:
            begin
                cmd.int_upd = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next = ST_ACC_P;
            end
            ST_ACC_P:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_sel = MUL_I;
                state_next = ST_ACC_I;
            end
            ST_ACC_I:
            begin
                cmd.acc_add = 1'b1;
                state_next = ST_WAIT_DIV;
            end
            ST_WAIT_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.mul_en = 1'b1;
                    cmd.mul_sel = MUL_D;
                    state_next = ST_ACC_D;
                end
            end
            ST_ACC_D:
            begin
                cmd.acc_add = 1'b1;
                cmd.commit_last = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            zero_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            zero_reg <= zero_next;
        end
    end

endmodule

[sv/pid_controller_clamped.sv]
// PID controller step in Q16.16 with a clamped integral and a clamped output.
// Each input word carries an error sample and a time step; each produces exactly
// one output word. The length of a compute step is set by the bit-serial
// divider for the derivative, which forms a 49-bit quotient; the increment,
// proportional and integral products share one multiplier while the division
// runs, and the derivative product follows it. A clear command or a zero time
// step skips the computation and gives a zero result. The input is taken again
// in the cycle after the result is loaded, so the block works on one word at a
// time; a result still waiting in the output register holds the block until
// it is taken. Registers are to be written through the cfg port only while
// the block is idle (not enforced); a limit written as zero reads as 1000.0.
module pid_controller_clamped
    import pidc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // error_in [31:0], step_time [47:32]
    input  logic                  s_axis_tuser,  // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata   // drive [31:0]
);

    pidc_cmd_t                cmd;
    pidc_status_t             status;
    logic signed [DATA_W-1:0] result;
    logic                     out_load;
    logic                     out_free;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        drive_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    pidc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .out_load (out_load),
        .status   (status),
        .cmd      (cmd)
    );

    pidc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_axis_tuser),
        .in_error  (s_axis_tdata[DATA_W-1:0]),
        .in_dt     (s_axis_tdata[DATA_W+DT_W-1:DATA_W]),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            drive_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = drive_reg;

    // Only one word is in work: an accepted word blocks the input next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a word is in work");

    // A result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result register overwritten");

    // The derivative product uses a finished quotient.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_en && cmd.mul_sel == MUL_D) |-> status.div_done)
        else $error("derivative used before division finished");

    // State is only touched while an item is in work, never with the input open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.int_upd || cmd.commit_last || cmd.clear_state) |-> !s_axis_tready)
        else $error("state update outside a step");

endmodule
